>>> rtl/hbp_pkg.sv
package hbp_pkg;

   // Code table geometry and limits
   localparam int MAX_LEN        = 16;
   localparam int FIELD_CODE_MAX = 16;
   localparam int LEN_LIMIT      = (MAX_LEN < FIELD_CODE_MAX) ? MAX_LEN : FIELD_CODE_MAX;
   localparam int MAX_RESULTS    = 3;
   localparam int PAD_BYTES      = (MAX_LEN + 7) / 8;
   localparam int TABLE_DEPTH    = 256;
   localparam int CODE_W         = 16;
   localparam int LEN_W          = 5;
   localparam int ENTRY_W        = CODE_W + LEN_W;
   localparam int PEND_W         = 7;
   localparam int PCNT_W         = 3;
   localparam int ACC_W          = PEND_W + CODE_W;

   // Flush byte counts, capped at the result limit
   localparam int FLUSH_N_PEND  = (1 + PAD_BYTES > MAX_RESULTS) ? MAX_RESULTS : 1 + PAD_BYTES;
   localparam int FLUSH_N_EMPTY = (PAD_BYTES > MAX_RESULTS) ? MAX_RESULTS : PAD_BYTES;

   typedef enum logic [1:0] {
      MODE_LOAD   = 2'd0,
      MODE_ENCODE = 2'd1,
      MODE_FLUSH  = 2'd2
   } mode_type;

   // Group of bytes handed from the packer to the output buffer
   typedef struct packed {
      logic [1:0]      cnt;
      logic [2:0][7:0] data;
   } burst_type;

   // Saturate the length and clear stray code bits for a table write
   function automatic logic [ENTRY_W-1:0] load_entry(input logic [CODE_W-1:0] bits,
                                                     input logic [LEN_W-1:0]  len);
      logic [LEN_W-1:0]  slen;
      logic [CODE_W:0]   mask;
      begin
         slen = (len > LEN_W'(LEN_LIMIT)) ? LEN_W'(LEN_LIMIT) : len;
         mask = (17'd1 << slen) - 17'd1;
         return {slen, bits & mask[CODE_W-1:0]};
      end
   endfunction

endpackage

>>> rtl/hbp_ram.sv
module hbp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // One write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/hbp_packer.sv
module hbp_packer (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        take,
   input  logic [1:0]                  take_mode,
   input  logic [hbp_pkg::ENTRY_W-1:0] entry,
   input  logic                        advance,
   output logic                        busy,
   output hbp_pkg::burst_type          burst
);
   import hbp_pkg::*;

   logic              s1_valid_ff, s1_valid_in;
   logic [1:0]        s1_mode_ff, s1_mode_in;
   logic [PEND_W-1:0] pend_bits_ff, pend_bits_in;
   logic [PCNT_W-1:0] pend_cnt_ff, pend_cnt_in;

   logic [LEN_W-1:0]  clen;
   logic [ACC_W-1:0]  acc;
   logic [LEN_W-1:0]  total;
   logic [PCNT_W-1:0] new_cnt;
   logic [PEND_W-1:0] new_bits;
   logic [PEND_W:0]   new_mask;

   // Stage register: one item held while its entry comes out of the table
   always_comb begin
      s1_valid_in = s1_valid_ff;
      s1_mode_in  = s1_mode_ff;
      if (take) begin
         s1_valid_in = 1'b1;
         s1_mode_in  = take_mode;
      end else if (advance) begin
         s1_valid_in = 1'b0;
      end
   end

   // Append code bits to the pending bits
   always_comb begin
      clen = entry[ENTRY_W-1:CODE_W];
      if (clen > LEN_W'(FIELD_CODE_MAX)) begin
         clen = LEN_W'(FIELD_CODE_MAX);
      end
      acc   = ACC_W'(pend_bits_ff) | (ACC_W'(entry[CODE_W-1:0]) << pend_cnt_ff);
      total = LEN_W'(pend_cnt_ff) + clen;
      new_cnt  = total[PCNT_W-1:0];
      new_mask = (8'd1 << new_cnt) - 8'd1;
      unique case (total[4:3])
         2'd0:    new_bits = acc[6:0];
         2'd1:    new_bits = acc[14:8];
         default: new_bits = acc[22:16];
      endcase
      new_bits = new_bits & new_mask[PEND_W-1:0];
   end

   // Bytes for the output buffer and next pending state
   always_comb begin
      burst        = '0;
      pend_bits_in = pend_bits_ff;
      pend_cnt_in  = pend_cnt_ff;
      unique case (s1_mode_ff)
         MODE_ENCODE: begin
            burst.cnt     = total[4:3];
            burst.data[0] = acc[7:0];
            burst.data[1] = acc[15:8];
            burst.data[2] = {1'b0, acc[22:16]};
            pend_bits_in  = new_bits;
            pend_cnt_in   = new_cnt;
         end
         MODE_FLUSH: begin
            if (pend_cnt_ff != '0) begin
               burst.cnt     = 2'(FLUSH_N_PEND);
               burst.data[0] = {1'b0, pend_bits_ff};
            end else begin
               burst.cnt = 2'(FLUSH_N_EMPTY);
            end
            pend_bits_in = '0;
            pend_cnt_in  = '0;
         end
         default: begin
            // load and unused codes give no bytes
            burst.cnt = 2'd0;
         end
      endcase
      if (!advance) begin
         pend_bits_in = pend_bits_ff;
         pend_cnt_in  = pend_cnt_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         pend_bits_ff <= '0;
         pend_cnt_ff  <= '0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         pend_bits_ff <= pend_bits_in;
         pend_cnt_ff  <= pend_cnt_in;
      end
      s1_mode_ff <= s1_mode_in;
   end

   assign busy = s1_valid_ff;

endmodule

>>> rtl/hbp_out_buf.sv
module hbp_out_buf (
   input  logic               clock,
   input  logic               reset,
   input  logic               load,
   input  hbp_pkg::burst_type burst,
   output logic               free,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [7:0]         rsp_out_byte,
   output logic               rsp_last
);
   import hbp_pkg::*;

   logic [1:0]      cnt_ff, cnt_in;
   logic [2:0][7:0] data_ff, data_in;
   logic            pop;

   assign pop  = rsp_valid && rsp_ready;
   assign free = (cnt_ff == 2'd0) || ((cnt_ff == 2'd1) && rsp_ready);

   // Byte queue: refill from the packer, else shift out one byte on each rsp_ handshake
   always_comb begin
      cnt_in  = cnt_ff;
      data_in = data_ff;
      if (load) begin
         cnt_in  = burst.cnt;
         data_in = burst.data;
      end else if (pop) begin
         cnt_in  = cnt_ff - 2'd1;
         data_in = {8'd0, data_ff[2], data_ff[1]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
      data_ff <= data_in;
   end

   assign rsp_valid    = (cnt_ff != 2'd0);
   assign rsp_out_byte = data_ff[0];
   assign rsp_last     = (cnt_ff == 2'd1);

endmodule

>>> rtl/huffman_bit_packer.sv
// An accepted item waits in the stage register while its table entry is read, then
//    its bytes are loaded into the output queue, which presents them on rsp_.
// One item per cycle is accepted while the output queue can take the stage's bytes;
//    an item's bytes (up to 2 for encode, 3 for flush) hold the byte-wide output until taken.
// Reset clears the pending bits, the stage and the output queue; the code table is
//    not cleared, and an entry must be loaded before its symbol is encoded.
module huffman_bit_packer (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_mode,
   input  logic [7:0]  req_symbol,
   input  logic [15:0] req_code_bits,
   input  logic [4:0]  req_code_len,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_out_byte,
   output logic        rsp_last
);
   import hbp_pkg::*;

   logic                take;
   logic                wr_en;
   logic                rd_en;
   logic [ENTRY_W-1:0]  entry;
   logic                busy;
   logic                free;
   logic                advance;
   burst_type           burst;

   // Handshake: the stage moves on whenever the output queue can take its bytes
   assign advance   = busy && free;
   assign req_ready = !reset && (!busy || free);
   assign take      = req_valid && req_ready;
   assign wr_en     = take && (req_mode == MODE_LOAD);
   assign rd_en     = take && (req_mode == MODE_ENCODE);

   hbp_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (TABLE_DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (req_symbol),
      .wr_data (load_entry(req_code_bits, req_code_len)),
      .rd_en   (rd_en),
      .rd_addr (req_symbol),
      .rd_data (entry)
   );

   hbp_packer u_packer (
      .clock     (clock),
      .reset     (reset),
      .take      (take),
      .take_mode (req_mode),
      .entry     (entry),
      .advance   (advance),
      .busy      (busy),
      .burst     (burst)
   );

   hbp_out_buf u_out_buf (
      .clock        (clock),
      .reset        (reset),
      .load         (advance),
      .burst        (burst),
      .free         (free),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_out_byte (rsp_out_byte),
      .rsp_last     (rsp_last)
   );

endmodule
